### hw/rtl/m3inv_pkg.sv
// shared types, widths and minor tables for the 3x3 inverse
package m3inv_pkg;

    localparam int EW   = 32;   // element width
    localparam int PW   = 64;   // element product width
    localparam int AW   = 65;   // adjugate entry width, signed
    localparam int MW   = 64;   // adjugate magnitude width
    localparam int TW   = 97;   // determinant term width, signed
    localparam int DW   = 98;   // determinant sum width, signed
    localparam int DMW  = 96;   // determinant magnitude width
    localparam int NUMW = 98;   // dividend width
    localparam int DENW = 97;   // divisor width
    localparam int QW   = 32;   // quotient bits produced
    localparam int CMPW = 130;  // compare width for shifted divisor
    localparam int LANES = 9;
    localparam int FRONT_LAT = 6;
    localparam int LAT = FRONT_LAT + QW + 2;

    localparam logic [EW-1:0] THR_RESET = 32'd4;

    typedef logic signed [EW-1:0] t_elem;

    typedef struct packed {
        logic          neg;
        logic [MW-1:0] nmag;
    } t_lane_in;

    // each adjugate entry is pa_x*pa_y - pb_x*pb_y, cofactor sign folded in
    localparam logic [3:0] PA_X [LANES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] PA_Y [LANES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] PB_X [LANES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] PB_Y [LANES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

### hw/rtl/m3inv_in_if.sv
// input channel: one matrix per item
interface m3inv_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

### hw/rtl/m3inv_out_if.sv
// output channel: one inverse with flags per item
interface m3inv_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic        singular;
    logic        saturated;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, singular, saturated, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, singular, saturated, output ready);
endinterface

### hw/rtl/m3inv_adj.sv
// adjugate and determinant pipeline, six stages, feeds the divider lanes
module m3inv_adj (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  m3inv_pkg::t_elem              i_m [m3inv_pkg::LANES],
    input  logic [31:0]                   i_thr,
    output m3inv_pkg::t_lane_in           o_lane [m3inv_pkg::LANES],
    output logic [m3inv_pkg::DMW-1:0]     o_dmag,
    output logic                          o_sing
);
    import m3inv_pkg::*;

    logic signed [PW-1:0] r_pa [LANES];
    logic signed [PW-1:0] r_pb [LANES];
    t_elem                r_row1 [3];
    t_elem                r_row2 [3];
    logic signed [AW-1:0] r_adj2 [LANES];
    logic signed [AW-1:0] r_adj3 [LANES];
    logic signed [AW-1:0] r_adj4 [LANES];
    logic signed [AW-1:0] r_adj5 [LANES];
    logic [63:0]          r_lo [3];
    logic [63:0]          r_hi [3];
    logic                 r_tneg [3];
    logic signed [TW-1:0] r_term [3];
    logic signed [DW-1:0] r_det;
    logic [DMW-1:0]       r_dmag;
    logic                 r_sing;
    t_lane_in             r_lane [LANES];

    logic [MW-1:0]        n_amag [3];
    logic [EW-1:0]        n_mmag [3];
    logic [DMW-1:0]       n_tmag [3];
    logic [DW-1:0]        n_dabs;
    logic [DMW-1:0]       n_dmag;

    // term magnitudes for the determinant expansion along row 0
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_amag[t] = r_adj2[3*t][AW-1] ? MW'(-r_adj2[3*t]) : MW'(r_adj2[3*t]);
            n_mmag[t] = r_row2[t][EW-1] ? EW'(-r_row2[t]) : EW'(r_row2[t]);
            n_tmag[t] = {r_hi[t], 32'b0} + {32'b0, r_lo[t]};
        end
        n_dabs = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        n_dmag = n_dabs[DMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: element products
            for (int l = 0; l < LANES; l++) begin
                r_pa[l] <= PW'(i_m[PA_X[l]]) * PW'(i_m[PA_Y[l]]);
                r_pb[l] <= PW'(i_m[PB_X[l]]) * PW'(i_m[PB_Y[l]]);
            end
            for (int t = 0; t < 3; t++) begin
                r_row1[t] <= i_m[t];
                r_row2[t] <= r_row1[t];
            end
            // stage 2: adjugate entries
            for (int l = 0; l < LANES; l++) begin
                r_adj2[l] <= {r_pa[l][PW-1], r_pa[l]} - {r_pb[l][PW-1], r_pb[l]};
                r_adj3[l] <= r_adj2[l];
                r_adj4[l] <= r_adj3[l];
                r_adj5[l] <= r_adj4[l];
            end
            // stage 3: split 64x32 products, stage 4: signed terms
            for (int t = 0; t < 3; t++) begin
                r_lo[t]   <= 64'(n_amag[t][31:0]) * 64'(n_mmag[t]);
                r_hi[t]   <= 64'(n_amag[t][63:32]) * 64'(n_mmag[t]);
                r_tneg[t] <= r_adj2[3*t][AW-1] ^ r_row2[t][EW-1];
                r_term[t] <= r_tneg[t] ? -$signed({1'b0, n_tmag[t]})
                                       : $signed({1'b0, n_tmag[t]});
            end
            // stage 5: determinant
            r_det <= DW'(r_term[0]) + DW'(r_term[1]) + DW'(r_term[2]);
            // stage 6: magnitude, singular test, lane operands
            r_dmag <= n_dmag;
            r_sing <= (n_dmag == '0) || (n_dmag < {48'b0, i_thr, 16'b0});
            for (int l = 0; l < LANES; l++) begin
                r_lane[l].neg  <= r_adj5[l][AW-1] ^ r_det[DW-1];
                r_lane[l].nmag <= r_adj5[l][AW-1] ? MW'(-r_adj5[l]) : MW'(r_adj5[l]);
            end
        end
    end

    assign o_lane = r_lane;
    assign o_dmag = r_dmag;
    assign o_sing = r_sing;
endmodule

### hw/rtl/m3inv_div.sv
// one divider lane: rounded restoring division, one quotient bit a stage, then saturating clip
module m3inv_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  m3inv_pkg::t_lane_in        i_lane,
    input  logic [m3inv_pkg::DMW-1:0]  i_dmag,
    output logic [31:0]                o_val,
    output logic                       o_sat
);
    import m3inv_pkg::*;

    logic [NUMW-1:0] r_rem [QW+1];
    logic [DENW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];
    logic            r_neg [QW+1];
    logic            r_ovf [QW+1];

    logic [NUMW-1:0] n_num;
    logic [DENW-1:0] n_den;
    logic [CMPW-1:0] n_sh  [QW+1];
    logic            n_ge  [QW+1];
    logic [NUMW-1:0] n_rem [QW+1];
    logic [QW-1:0]   n_q   [QW+1];
    logic [QW-1:0]   n_lim;
    logic [QW-1:0]   n_mag;

    // rounded dividend and doubled divisor
    always_comb begin
        n_num = {1'b0, i_lane.nmag, 33'b0} + {2'b0, i_dmag};
        n_den = {i_dmag, 1'b0};
    end

    // per stage compare and subtract of the shifted divisor
    always_comb begin
        n_sh[0]  = '0;
        n_ge[0]  = 1'b0;
        n_rem[0] = '0;
        n_q[0]   = '0;
        for (int s = 1; s <= QW; s++) begin
            n_sh[s]  = {33'b0, r_den[s-1]} << (QW - s);
            n_ge[s]  = {32'b0, r_rem[s-1]} >= n_sh[s];
            n_rem[s] = n_ge[s] ? r_rem[s-1] - n_sh[s][NUMW-1:0] : r_rem[s-1];
            n_q[s]   = r_q[s-1] | (QW'(n_ge[s]) << (QW - s));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_den[0] <= n_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_lane.neg;
            r_ovf[0] <= {32'b0, n_num} >= {1'b0, n_den, 32'b0};
            for (int s = 1; s <= QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= n_q[s];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    // clip to the signed range and apply the sign
    always_comb begin
        n_lim = r_neg[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        o_sat = r_ovf[QW] || (r_q[QW] > n_lim);
        n_mag = o_sat ? n_lim : r_q[QW];
        o_val = r_neg[QW] ? -n_mag : n_mag;
    end
endmodule

### hw/rtl/matrix3x3_inverse.sv
// top level: 3x3 fixed-point inverse with nine divider lanes and a merge register
// One matrix is taken per clock while the pipeline is not held, and its inverse
// passes through 40 register stages. Six stages form the element products, the
// adjugate and the exact determinant. Nine lanes then each run a 33-stage
// restoring divider for one element: an operand stage with the overflow test,
// then one quotient bit a stage. A final register merges the lanes with the
// singular and saturation flags. The whole pipeline holds while a result waits
// unaccepted.
// The singular threshold should be written only while no item is in flight.
module matrix3x3_inverse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    m3inv_in_if.sink    i_in,
    m3inv_out_if.source o_out
);
    import m3inv_pkg::*;

    logic [31:0]    r_thr;
    logic           r_vld [LAT];
    logic           r_sing [QW+1];
    logic [31:0]    r_inv [LANES];
    logic           r_singular;
    logic           r_saturated;

    logic           n_en;
    t_elem          n_m [LANES];
    t_lane_in       n_lane [LANES];
    logic [DMW-1:0] n_dmag;
    logic           n_sing;
    logic [31:0]    n_val [LANES];
    logic           n_sat [LANES];
    logic           n_any;

    // pipeline advances whenever the output register is free or being drained
    assign n_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = n_en;

    assign n_m = '{i_in.m00, i_in.m01, i_in.m02, i_in.m10, i_in.m11, i_in.m12,
                   i_in.m20, i_in.m21, i_in.m22};

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    m3inv_adj u_adj (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_m    (n_m),
        .i_thr  (r_thr),
        .o_lane (n_lane),
        .o_dmag (n_dmag),
        .o_sing (n_sing)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        m3inv_div u_div (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_lane (n_lane[l]),
            .i_dmag (n_dmag),
            .o_val  (n_val[l]),
            .o_sat  (n_sat[l])
        );
    end

    // item valid track
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vld[s] <= 1'b0;
        end else if (n_en) begin
            r_vld[0] <= i_in.valid;
            for (int s = 1; s < LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // singular flag follows the divider stages
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sing[0] <= n_sing;
            for (int s = 1; s <= QW; s++) r_sing[s] <= r_sing[s-1];
        end
    end

    always_comb begin
        n_any = 1'b0;
        for (int l = 0; l < LANES; l++) n_any = n_any | n_sat[l];
    end

    // merge register
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            for (int l = 0; l < LANES; l++) r_inv[l] <= r_sing[QW] ? '0 : n_val[l];
            r_singular  <= r_sing[QW];
            r_saturated <= !r_sing[QW] && n_any;
        end
    end

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.inv00     = r_inv[0];
    assign o_out.inv01     = r_inv[1];
    assign o_out.inv02     = r_inv[2];
    assign o_out.inv10     = r_inv[3];
    assign o_out.inv11     = r_inv[4];
    assign o_out.inv12     = r_inv[5];
    assign o_out.inv20     = r_inv[6];
    assign o_out.inv21     = r_inv[7];
    assign o_out.inv22     = r_inv[8];
    assign o_out.singular  = r_singular;
    assign o_out.saturated = r_saturated;
endmodule
